>>> sv/selective_repeat_sender_window_assert.svh
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SRSW_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SRSW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/srsw_pkg.sv
package srsw_pkg;

  localparam int TOTAL_W    = 11;
  localparam int WIN_W      = 6;
  localparam int ACK_W      = 16;
  localparam int SEQ_W      = 10;
  localparam int BASE_W     = 11;
  localparam int OP_W       = 2;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  localparam logic KIND_SEND   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic REG_TOTAL  = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET  = 11'd0;
  localparam logic [WIN_W-1:0]   WINDOW_RESET = 6'd4;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_packets;
    logic [WIN_W-1:0]   window_size;
  } cfg_t;

endpackage

>>> sv/srsw_cfg.sv
module srsw_cfg
  import srsw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_packets <= TOTAL_RESET;
      cfg.window_size   <= WINDOW_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_TOTAL) begin
        cfg.total_packets <= pwdata[TOTAL_W-1:0];
      end else begin
        cfg.window_size <= pwdata[WIN_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_WINDOW) begin
      prdata = {{(APB_DATA_W-WIN_W){1'b0}}, cfg.window_size};
    end else begin
      prdata = {{(APB_DATA_W-TOTAL_W){1'b0}}, cfg.total_packets};
    end
  end

endmodule

>>> sv/selective_repeat_sender_window.sv
// Selective Repeat ARQ sender window. Each input item is an event (start,
// acknowledgement, timeout or an unused opcode) and answers with zero or
// more send requests followed by one status item that carries tlast. The
// acknowledged bitmap lives in a one-bit-wide memory of MAX_PACKETS entries
// with a registered read port, read one entry per cycle while the output is
// not stalled. An acknowledgement first slides the window base over the
// acknowledged entries; every event then scans the send window (at most the
// window size entries) and emits the status item, waiting while the output
// is stalled. A start first clears the bitmap entries up to the highest
// packet acknowledged since the last clear. After reset the whole memory is
// cleared before the first item is accepted; configuration writes are taken
// at any time.
`include "selective_repeat_sender_window_assert.svh"

module selective_repeat_sender_window
  import srsw_pkg::*;
#(
  parameter int MAX_PACKETS = 1024,
  parameter int MAX_WINDOW  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // ack_number[15:0]
  input  logic [OP_W-1:0]       s_tuser,   // opcode[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // seq[9:0], window_base[20:10], all_done[21]
  output logic                  m_tuser,   // kind[0]
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PW = $clog2(MAX_PACKETS + 1);
  localparam int AW = $clog2(MAX_PACKETS);
  localparam int EW = (PW > TOTAL_W) ? PW : TOTAL_W;
  localparam int CW = (PW > ACK_W) ? PW : ACK_W;
  localparam int LW = ((PW > WIN_W) ? PW : WIN_W) + 1;
  localparam int DATA_USED = SEQ_W + BASE_W + 1;

  localparam logic [EW-1:0]    MAX_PK_E = EW'(MAX_PACKETS);
  localparam logic [PW-1:0]    MAX_PK   = PW'(MAX_PACKETS);
  localparam logic [WIN_W-1:0] MAX_WIN  = WIN_W'(MAX_WINDOW);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_CLEAR     = 3'd1;
  localparam logic [2:0] ST_SLIDE_RD  = 3'd2;
  localparam logic [2:0] ST_SLIDE_CHK = 3'd3;
  localparam logic [2:0] ST_SEND_INIT = 3'd4;
  localparam logic [2:0] ST_SEND_RD   = 3'd5;
  localparam logic [2:0] ST_SEND_CHK  = 3'd6;
  localparam logic [2:0] ST_STATUS    = 3'd7;

  cfg_t cfg;

  srsw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic            acked_mem [MAX_PACKETS];
  logic            rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic            mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;

  logic [2:0]      state, state_next;
  logic [PW-1:0]   base_ptr, base_next;
  logic [PW-1:0]   next_ptr, next_next;
  logic [PW-1:0]   limit, limit_next;
  logic            done_flag, done_next;
  logic [PW-1:0]   hw, hw_next;
  logic [PW-1:0]   clr_ptr, clr_next;
  logic            send_after_clear, send_after_clear_next;

  logic            ovalid;
  logic            okind;
  logic [SEQ_W-1:0]  oseq;
  logic [BASE_W-1:0] obase;
  logic            odone;
  logic            olast;
  logic            oload;
  logic            okind_n;
  logic            olast_n;

  logic [EW-1:0]   total_e;
  logic [PW-1:0]   eff_total;
  logic [WIN_W-1:0] eff_win;
  logic            accept;
  logic            can_emit;
  logic [CW-1:0]   ack_e;
  logic [CW-1:0]   ack_inc;
  logic [PW-1:0]   ack_lim;
  logic            ack_ok;
  logic [PW-1:0]   base_plus;
  logic [PW-1:0]   next_plus;
  logic [LW-1:0]   win_end;
  logic [PW-1:0]   lim_calc;

  assign total_e   = EW'(cfg.total_packets);
  assign eff_total = (total_e > MAX_PK_E) ? MAX_PK : total_e[PW-1:0];
  assign eff_win   = (cfg.window_size > MAX_WIN) ? MAX_WIN : cfg.window_size;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign can_emit  = !ovalid || m_tready;

  assign ack_e     = CW'(s_tdata);
  assign ack_inc   = ack_e + CW'(1);
  assign ack_lim   = ack_inc[PW-1:0];
  assign ack_ok    = (ack_e >= CW'(base_ptr)) && (ack_e < CW'(eff_total));

  assign base_plus = base_ptr + PW'(1);
  assign next_plus = next_ptr + PW'(1);
  assign win_end   = LW'(base_ptr) + LW'(eff_win);
  assign lim_calc  = (win_end > LW'(eff_total)) ? eff_total : win_end[PW-1:0];

  always_comb begin
    state_next            = state;
    base_next             = base_ptr;
    next_next             = next_ptr;
    limit_next            = limit;
    done_next             = done_flag;
    hw_next               = hw;
    clr_next              = clr_ptr;
    send_after_clear_next = send_after_clear;
    mem_we                = 1'b0;
    mem_waddr             = s_tdata[AW-1:0];
    mem_wdata             = 1'b1;
    mem_re                = 1'b0;
    mem_raddr             = base_ptr[AW-1:0];
    oload                 = 1'b0;
    okind_n               = KIND_SEND;
    olast_n               = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            OP_START: begin
              base_next             = '0;
              next_next             = '0;
              clr_next              = '0;
              send_after_clear_next = 1'b1;
              state_next            = ST_CLEAR;
            end
            OP_ACK: begin
              if (ack_ok) begin
                mem_we = 1'b1;
                if (ack_lim > hw) begin
                  hw_next = ack_lim;
                end
                state_next = ST_SLIDE_RD;
              end else begin
                state_next = ST_SEND_INIT;
              end
            end
            OP_TIMEOUT: begin
              next_next  = base_ptr;
              state_next = ST_SEND_INIT;
            end
            default: begin
              state_next = ST_SEND_INIT;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_ptr < hw) begin
          mem_we    = 1'b1;
          mem_waddr = clr_ptr[AW-1:0];
          mem_wdata = 1'b0;
          clr_next  = clr_ptr + PW'(1);
        end else begin
          hw_next    = '0;
          state_next = send_after_clear ? ST_SEND_INIT : ST_IDLE;
        end
      end
      ST_SLIDE_RD: begin
        if (base_ptr < eff_total) begin
          mem_re     = 1'b1;
          mem_raddr  = base_ptr[AW-1:0];
          state_next = ST_SLIDE_CHK;
        end else begin
          state_next = ST_SEND_INIT;
        end
      end
      ST_SLIDE_CHK: begin
        if (rdata) begin
          base_next = base_plus;
          if (base_plus < eff_total) begin
            mem_re    = 1'b1;
            mem_raddr = base_plus[AW-1:0];
          end else begin
            state_next = ST_SEND_INIT;
          end
        end else begin
          state_next = ST_SEND_INIT;
        end
      end
      ST_SEND_INIT: begin
        done_next  = (base_ptr >= eff_total);
        limit_next = lim_calc;
        if (next_ptr < base_ptr) begin
          next_next = base_ptr;
        end
        state_next = ST_SEND_RD;
      end
      ST_SEND_RD: begin
        if (next_ptr < limit) begin
          mem_re     = 1'b1;
          mem_raddr  = next_ptr[AW-1:0];
          state_next = ST_SEND_CHK;
        end else begin
          state_next = ST_STATUS;
        end
      end
      ST_SEND_CHK: begin
        if (rdata || can_emit) begin
          oload     = !rdata;
          next_next = next_plus;
          if (next_plus < limit) begin
            mem_re    = 1'b1;
            mem_raddr = next_plus[AW-1:0];
          end else begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (can_emit) begin
          oload      = 1'b1;
          okind_n    = KIND_STATUS;
          olast_n    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      acked_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= acked_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      base_ptr         <= '0;
      next_ptr         <= '0;
      done_flag        <= 1'b0;
      hw               <= MAX_PK;
      clr_ptr          <= '0;
      send_after_clear <= 1'b0;
    end else begin
      state            <= state_next;
      base_ptr         <= base_next;
      next_ptr         <= next_next;
      done_flag        <= done_next;
      hw               <= hw_next;
      clr_ptr          <= clr_next;
      send_after_clear <= send_after_clear_next;
    end
  end

  always_ff @(posedge clk) begin
    limit <= limit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (oload) begin
      ovalid <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (oload) begin
      okind <= okind_n;
      oseq  <= (okind_n == KIND_STATUS) ? '0 : SEQ_W'(next_ptr);
      obase <= BASE_W'(base_ptr);
      odone <= done_flag;
      olast <= olast_n;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tuser  = okind;
  assign m_tlast  = olast;
  assign m_tdata  = {{(M_TDATA_W-DATA_USED){1'b0}}, odone, obase, oseq};

  `SRSW_ASSERT_IMPL(a_last_is_status, m_tvalid && m_tlast, m_tuser == KIND_STATUS,
                    "An item with tlast is not a status item.")
  `SRSW_ASSERT_IMPL(a_no_send_when_done, m_tvalid && (m_tuser == KIND_SEND), !odone,
                    "A send request was issued after the transfer completed.")
  `SRSW_ASSERT_IMPL(a_scan_in_window, state == ST_SEND_CHK,
                    (next_ptr < limit) && (limit <= eff_total),
                    "The send scan left the window.")
  `SRSW_ASSERT_NEXT(a_clear_resets_mark, (state == ST_CLEAR) && (clr_ptr >= hw), hw == '0,
                    "The high-water mark was not reset after the clearing pass.")

endmodule

>>> tb/selective_repeat_sender_window_checker.sv
`timescale 1ns / 100ps

module selective_repeat_sender_window_checker
  import srsw_pkg::*;
#(
  parameter int MAX_PACKETS = 1024,
  parameter int MAX_WINDOW  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // ack_number[15:0]
  input  logic [OP_W-1:0]       s_tuser,   // opcode[1:0]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,   // seq[9:0], window_base[20:10], all_done[21]
  input  logic                  m_tuser,   // kind[0]
  input  logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  seq;
    logic [BASE_W-1:0] base;
    logic              done;
    logic              last;
  } window_result_t;

  window_result_t     expected_results[$];
  logic               acked [MAX_PACKETS];
  int                 base_seq;
  int                 next_seq;
  logic [TOTAL_W-1:0] total_reg;
  logic [WIN_W-1:0]   window_reg;

  function automatic window_result_t make_result(input logic kind, input int seq,
                                                 input int base, input logic done);
    window_result_t r;
    r.kind = kind;
    r.seq  = seq[SEQ_W-1:0];
    r.base = base[BASE_W-1:0];
    r.done = done;
    r.last = (kind == KIND_STATUS);
    return r;
  endfunction

  task automatic apply_event(input logic [OP_W-1:0] op, input int ack);
    int   total_eff;
    int   win_eff;
    int   limit_seq;
    logic done;
    total_eff = (int'(total_reg) > MAX_PACKETS) ? MAX_PACKETS : int'(total_reg);
    win_eff   = (int'(window_reg) > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg);
    if (op == OP_START) begin
      foreach (acked[i]) acked[i] = 1'b0;
      base_seq = 0;
      next_seq = 0;
    end else if (op == OP_ACK) begin
      if (ack >= base_seq && ack < total_eff) begin
        acked[ack] = 1'b1;
        while (base_seq < total_eff && acked[base_seq]) base_seq++;
      end
    end else if (op == OP_TIMEOUT) begin
      next_seq = base_seq;
    end
    done = (base_seq >= total_eff);
    if (next_seq < base_seq) next_seq = base_seq;
    limit_seq = (base_seq + win_eff > total_eff) ? total_eff : base_seq + win_eff;
    while (next_seq < limit_seq) begin
      if (!acked[next_seq]) begin
        expected_results.push_back(make_result(KIND_SEND, next_seq, base_seq, done));
      end
      next_seq++;
    end
    expected_results.push_back(make_result(KIND_STATUS, 0, base_seq, done));
  endtask

  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    if (rst) begin
      expected_results.delete();
      foreach (acked[i]) acked[i] = 1'b0;
      base_seq   = 0;
      next_seq   = 0;
      total_reg  = TOTAL_RESET;
      window_reg = WINDOW_RESET;
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.seq  = m_tdata[SEQ_W-1:0];
        got.base = m_tdata[SEQ_W +: BASE_W];
        got.done = m_tdata[SEQ_W + BASE_W];
        got.last = m_tlast;
        if (expected_results.size() == 0) begin
          $display("%0t: expected none, got kind=%0d seq=%0d base=%0d done=%0d last=%0d",
                   $time, got.kind, got.seq, got.base, got.done, got.last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected kind=%0d seq=%0d base=%0d done=%0d last=%0d",
                     $time, want.kind, want.seq, want.base, want.done, want.last);
            $display("%0t:                     got kind=%0d seq=%0d base=%0d done=%0d last=%0d",
                     $time, got.kind, got.seq, got.base, got.done, got.last);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_event(s_tuser, int'(s_tdata));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_TOTAL, 2'b00}) begin
          total_reg = pwdata[TOTAL_W-1:0];
        end else if (paddr == {REG_WINDOW, 2'b00}) begin
          window_reg = pwdata[WIN_W-1:0];
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

>>> tb/selective_repeat_sender_window_tb.sv
`timescale 1ns / 100ps

module selective_repeat_sender_window_tb;
  import srsw_pkg::*;

  localparam int MAX_PACKETS    = 1024;
  localparam int MAX_WINDOW     = 32;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 38;
  localparam int NUM_PHASES     = 8;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;   // ack_number[15:0]
  logic [OP_W-1:0]       s_tuser;   // opcode[1:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;   // seq[9:0], window_base[20:10], all_done[21]
  logic                  m_tuser;   // kind[0]
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int idle_cycles;
  int oldest_open;
  int run_total;
  int run_window;
  bit sent_acked [MAX_PACKETS];

  int phase_total [NUM_PHASES]   = '{12, 1024, 2047, 1, 0, 64, 100, 40};
  int phase_window [NUM_PHASES]  = '{4, 32, 63, 1, 4, 0, 17, 8};
  int sender_idle_pct [4]        = '{0, 52, 0, 23};
  int receiver_stall_pct [4]     = '{0, 0, 52, 23};

  selective_repeat_sender_window #(
    .MAX_PACKETS(MAX_PACKETS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dut (.*);

  selective_repeat_sender_window_checker #(
    .MAX_PACKETS(MAX_PACKETS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_check (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_event(input logic [OP_W-1:0] op, input logic [ACK_W-1:0] ack);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ack;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input int total, input int window);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_TOTAL, total);
    write_reg(REG_WINDOW, window);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    run_total  = (total > MAX_PACKETS) ? MAX_PACKETS : total;
    run_window = (window > MAX_WINDOW) ? MAX_WINDOW : window;
  endtask

  task automatic start_transfer();
    send_event(OP_START, ACK_W'($urandom_range(16'hFFFF)));
    foreach (sent_acked[i]) sent_acked[i] = 1'b0;
    oldest_open = 0;
  endtask

  task automatic note_ack(input int a);
    if (a >= oldest_open && a < run_total) begin
      sent_acked[a] = 1'b1;
      while (oldest_open < run_total && sent_acked[oldest_open]) oldest_open++;
    end
  endtask

  // Mostly acknowledgements inside the open window, with timeouts, stray
  // numbers, unused opcodes and restarts mixed in.
  task automatic random_event();
    int r;
    int span;
    int a;
    r = $urandom_range(99);
    if ((oldest_open >= run_total && r < 50) || r < 3) begin
      start_transfer();
    end else if (r < 78) begin
      span = run_total - oldest_open;
      if (span > run_window) span = run_window;
      if (span < 1) span = 1;
      a = oldest_open + $urandom_range(span - 1);
      send_event(OP_ACK, a[ACK_W-1:0]);
      note_ack(a);
    end else if (r < 88) begin
      send_event(OP_TIMEOUT, ACK_W'($urandom_range(16'hFFFF)));
    end else if (r < 96) begin
      a = $urandom_range(16'hFFFF);
      send_event(OP_ACK, a[ACK_W-1:0]);
      note_ack(a);
    end else begin
      send_event(OP_UNUSED, ACK_W'($urandom_range(16'hFFFF)));
    end
  endtask

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_START;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    idle_pct    = 0;
    stall_pct   = 0;
    oldest_open = 0;
    run_total   = 0;
    run_window  = 4;
    phase_total[NUM_PHASES-1]  = $urandom_range(2, 200);
    phase_window[NUM_PHASES-1] = $urandom_range(1, 32);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Events that arrive before any start act on the reset state.
    send_event(OP_ACK, 16'd0);
    send_event(OP_TIMEOUT, 16'd0);

    configure(10, 4);
    start_transfer();
    send_event(OP_ACK, 16'd0);
    send_event(OP_ACK, 16'd2);
    send_event(OP_ACK, 16'd1);
    send_event(OP_ACK, 16'd1);
    send_event(OP_ACK, 16'd10);
    send_event(OP_ACK, 16'hFFFF);
    send_event(OP_TIMEOUT, 16'hFFFF);
    send_event(OP_UNUSED, 16'h5A5A);
    for (int i = 9; i >= 3; i--) begin
      send_event(OP_ACK, i[ACK_W-1:0]);
    end
    send_event(OP_TIMEOUT, 16'd0);

    // Oversized window, then the total is lowered below the current base.
    configure(40, 63);
    start_transfer();
    send_event(OP_ACK, 16'd0);
    send_event(OP_ACK, 16'd1);
    send_event(OP_ACK, 16'd5);
    configure(1, 0);
    send_event(OP_TIMEOUT, 16'd0);
    send_event(OP_ACK, 16'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(phase_total[p], phase_window[p]);
      idle_pct  = sender_idle_pct[p % 4];
      stall_pct = receiver_stall_pct[p % 4];
      start_transfer();
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        random_event();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
